@@ hw/rtl/afh_pkg.sv @@
// Shared constants and types for the AFH channel map engine.
// Used by afh_mod_unit and afh_channel_map_engine; depends on nothing.
package afh_pkg;

    localparam int MAX_CHANNELS = 128;
    localparam int ADDR_W       = $clog2(MAX_CHANNELS);
    localparam int COUNT_W      = $clog2(MAX_CHANNELS + 1);
    localparam int CH_W         = 7;
    localparam int MAP_LIMIT    = (MAX_CHANNELS < 128) ? MAX_CHANNELS : 128;

    // serial modulo unit sizing: pn_value + hop_step fits 9 bits
    localparam int MOD_DVD_W = 9;
    localparam int MOD_DIV_W = 8;
    localparam int MOD_CNT_W = $clog2(MOD_DVD_W + 1);

    // channel status codes
    localparam logic [1:0] ST_UNAVAIL = 2'd0;
    localparam logic [1:0] ST_AVAIL   = 2'd1;
    localparam logic [1:0] ST_USED    = 2'd2;

    localparam logic [1:0] LOSS_LIMIT = 2'd3;

    // operation codes
    localparam logic [1:0] OP_ASSESS  = 2'd0;
    localparam logic [1:0] OP_MAP     = 2'd1;
    localparam logic [1:0] OP_MONITOR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SNR_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRR_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REMAP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE  = 3'd6;

    // one channel table entry
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] loss;
    } entry_t;

endpackage

@@ hw/rtl/afh_channel_map_engine.sv @@
// Top level of the AFH channel map engine: config registers, channel table
// memory and the operation sequencer. Depends on afh_pkg and afh_mod_unit.
//
// One word is taken at a time. Assess and monitor without replacement go
// through evaluate and push; map first waits for the serial modulo. A
// stepped map that hits an unavailable channel, or a monitor that replaces,
// also walks the channel table one entry per cycle through its single read
// port, up to the whole table, and a stepped map runs a second modulo
// before the walk. A finished result waits in the output register while
// the next word is taken. The table needs no clearing pass after reset:
// per-entry valid flops make untouched entries read as unavailable.
module afh_channel_map_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [afh_pkg::CH_W-1:0]        channel,
    input  logic [7:0]                      pn_value,
    input  logic [7:0]                      rssi,
    input  logic [7:0]                      snr,
    input  logic [7:0]                      prr,
    // result words
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [afh_pkg::CH_W-1:0]        result_channel,
    output logic                            quality_ok,
    output logic                            none_available,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [afh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MODC  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_MODK  = 3'd3;
    localparam logic [2:0] S_SCAN0 = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    localparam int AW = afh_pkg::ADDR_W;
    localparam int CW = afh_pkg::COUNT_W;

    // configuration
    logic [7:0] rssi_thr_reg, snr_thr_reg, prr_thr_reg, num_ch_reg;
    logic [6:0] hop_step_reg;
    logic       remap_reg, replace_reg;

    // sequencer
    logic [2:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [AW-1:0]        ch_reg, ch_next;
    logic                 ok_reg, ok_next;
    logic [AW-1:0]        c_reg, c_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        scan_idx_reg, scan_idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [afh_pkg::CH_W-1:0] res_ch_reg, res_ch_next;
    logic                 res_q_reg, res_q_next;
    logic                 res_none_reg, res_none_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [afh_pkg::CH_W-1:0] out_ch_reg, out_ch_next;
    logic                 out_q_reg, out_q_next;
    logic                 out_none_reg, out_none_next;

    // channel table
    afh_pkg::entry_t      mem [afh_pkg::MAX_CHANNELS];
    logic [afh_pkg::MAX_CHANNELS-1:0] valid_reg;
    afh_pkg::entry_t      mem_q;
    logic                 rd_valid_reg;
    afh_pkg::entry_t      rd_entry;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    afh_pkg::entry_t      mem_wdata;
    logic [1:0]           wr_old_st;

    // modulo unit
    logic                             mod_start;
    logic [afh_pkg::MOD_DVD_W-1:0]    mod_dividend;
    logic [afh_pkg::MOD_DIV_W-1:0]    mod_divisor;
    logic                             mod_busy;
    logic [afh_pkg::MOD_DIV_W-1:0]    mod_rem;

    logic                 ok_now;
    logic [7:0]           n_sat;
    logic [1:0]           loss_new;
    logic                 push_ok;

    afh_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_thr_reg <= 8'd50;
            snr_thr_reg  <= 8'd50;
            prr_thr_reg  <= 8'd50;
            num_ch_reg   <= 8'd79;
            hop_step_reg <= 7'd7;
            remap_reg    <= 1'b1;
            replace_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                afh_pkg::REG_RSSI_THR: rssi_thr_reg <= cfg_data;
                afh_pkg::REG_SNR_THR:  snr_thr_reg  <= cfg_data;
                afh_pkg::REG_PRR_THR:  prr_thr_reg  <= cfg_data;
                afh_pkg::REG_NUM_CH:   num_ch_reg   <= cfg_data;
                afh_pkg::REG_HOP_STEP: hop_step_reg <= cfg_data[6:0];
                afh_pkg::REG_REMAP:    remap_reg    <= cfg_data[0];
                afh_pkg::REG_REPLACE:  replace_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign ok_now = !(rssi < rssi_thr_reg && snr < snr_thr_reg && prr < prr_thr_reg);

    always_comb
    begin
        if (num_ch_reg == 8'd0)
            n_sat = 8'd1;
        else if (num_ch_reg > 8'(afh_pkg::MAP_LIMIT))
            n_sat = 8'(afh_pkg::MAP_LIMIT);
        else
            n_sat = num_ch_reg;
    end

    // entries never written read as unavailable with zero losses
    assign rd_entry = rd_valid_reg ? mem_q : '0;

    always_comb
    begin
        if (ok_reg)
            loss_new = 2'd0;
        else if (rd_entry.loss == afh_pkg::LOSS_LIMIT)
            loss_new = afh_pkg::LOSS_LIMIT;
        else
            loss_new = rd_entry.loss + 2'd1;
    end

    assign push_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        ch_next       = ch_reg;
        ok_next       = ok_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        scan_idx_next = scan_idx_reg;
        res_ch_next   = res_ch_reg;
        res_q_next    = res_q_reg;
        res_none_next = res_none_reg;
        out_valid_next = out_valid_reg;
        out_ch_next   = out_ch_reg;
        out_q_next    = out_q_reg;
        out_none_next = out_none_reg;
        rd_addr       = ch_reg;
        mem_we        = 1'b0;
        mem_waddr     = ch_reg;
        mem_wdata     = '0;
        wr_old_st     = afh_pkg::ST_UNAVAIL;
        mod_start     = 1'b0;
        mod_dividend  = '0;
        mod_divisor   = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = AW'(channel);
                if (in_valid)
                begin
                    op_next       = operation;
                    ch_next       = AW'(channel);
                    ok_next       = ok_now;
                    res_ch_next   = channel;
                    res_q_next    = ok_now;
                    res_none_next = 1'b0;
                    case (operation)
                        afh_pkg::OP_ASSESS,
                        afh_pkg::OP_MONITOR:
                            state_next = S_EVAL;
                        afh_pkg::OP_MAP:
                        begin
                            res_q_next  = 1'b0;
                            mod_start   = 1'b1;
                            mod_divisor = n_sat;
                            if (remap_reg)
                                mod_dividend = {1'b0, pn_value} + {2'b00, hop_step_reg};
                            else
                                mod_dividend = {1'b0, pn_value};
                            state_next = S_MODC;
                        end
                        default:
                        begin
                            res_ch_next = '0;
                            res_q_next  = 1'b0;
                            state_next  = S_PUSH;
                        end
                    endcase
                end
            end

            S_MODC:
            begin
                rd_addr = AW'(mod_rem);
                if (!mod_busy)
                begin
                    c_next      = AW'(mod_rem);
                    res_ch_next = afh_pkg::CH_W'(mod_rem);
                    state_next  = S_EVAL;
                end
            end

            S_EVAL:
            begin
                wr_old_st = rd_entry.status;
                case (op_reg)
                    afh_pkg::OP_ASSESS:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ch_reg;
                        mem_wdata.status = ok_reg ? afh_pkg::ST_AVAIL : afh_pkg::ST_UNAVAIL;
                        mem_wdata.loss   = rd_entry.loss;
                        state_next = S_PUSH;
                    end
                    afh_pkg::OP_MAP:
                    begin
                        if (remap_reg && rd_entry.status == afh_pkg::ST_UNAVAIL)
                        begin
                            if (count_reg == '0)
                            begin
                                res_none_next = 1'b1;
                                state_next    = S_PUSH;
                            end
                            else
                            begin
                                mod_start    = 1'b1;
                                mod_dividend = afh_pkg::MOD_DVD_W'(c_reg);
                                mod_divisor  = afh_pkg::MOD_DIV_W'(count_reg);
                                state_next   = S_MODK;
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = c_reg;
                            mem_wdata.status = afh_pkg::ST_USED;
                            mem_wdata.loss   = rd_entry.loss;
                            state_next = S_PUSH;
                        end
                    end
                    default:
                    begin
                        // monitor
                        mem_we    = 1'b1;
                        mem_waddr = ch_reg;
                        mem_wdata.loss = loss_new;
                        if (loss_new == afh_pkg::LOSS_LIMIT)
                        begin
                            mem_wdata.status = afh_pkg::ST_UNAVAIL;
                            if (replace_reg)
                            begin
                                k_next     = '0;
                                state_next = S_SCAN0;
                            end
                            else
                                state_next = S_PUSH;
                        end
                        else
                        begin
                            mem_wdata.status = rd_entry.status;
                            state_next = S_PUSH;
                        end
                    end
                endcase
            end

            S_MODK:
            begin
                if (!mod_busy)
                begin
                    k_next     = AW'(mod_rem);
                    state_next = S_SCAN0;
                end
            end

            S_SCAN0:
            begin
                rd_addr       = '0;
                scan_idx_next = '0;
                if (count_reg == '0)
                begin
                    res_none_next = 1'b1;
                    state_next    = S_PUSH;
                end
                else
                    state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // data for scan_idx arrives while the next entry is read
                rd_addr       = scan_idx_reg + 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (rd_entry.status == afh_pkg::ST_AVAIL && k_reg == '0)
                begin
                    wr_old_st = afh_pkg::ST_AVAIL;
                    mem_we    = 1'b1;
                    mem_waddr = scan_idx_reg;
                    mem_wdata.status = afh_pkg::ST_USED;
                    mem_wdata.loss   = rd_entry.loss;
                    res_ch_next = afh_pkg::CH_W'(scan_idx_reg);
                    state_next  = S_PUSH;
                end
                else
                begin
                    if (rd_entry.status == afh_pkg::ST_AVAIL)
                        k_next = k_reg - 1'b1;
                    if (scan_idx_reg == AW'(afh_pkg::MAX_CHANNELS - 1))
                    begin
                        res_none_next = 1'b1;
                        state_next    = S_PUSH;
                    end
                end
            end

            S_PUSH:
            begin
                if (push_ok)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = res_ch_reg;
                    out_q_next     = res_q_reg;
                    out_none_next  = res_none_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // available count follows every status write
    always_comb
    begin
        count_next = count_reg;
        if (mem_we)
        begin
            if (wr_old_st == afh_pkg::ST_AVAIL && count_reg != '0)
                count_next = count_next - 1'b1;
            if (mem_wdata.status == afh_pkg::ST_AVAIL)
                count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                valid_reg[mem_waddr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        ok_reg       <= ok_next;
        c_reg        <= c_next;
        k_reg        <= k_next;
        scan_idx_reg <= scan_idx_next;
        res_ch_reg   <= res_ch_next;
        res_q_reg    <= res_q_next;
        res_none_reg <= res_none_next;
        out_ch_reg   <= out_ch_next;
        out_q_reg    <= out_q_next;
        out_none_reg <= out_none_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_channel = out_ch_reg;
    assign quality_ok     = out_q_reg;
    assign none_available = out_none_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(afh_pkg::MAX_CHANNELS))
        else $error("available count beyond table size");
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EVAL || state_reg == S_SCAN))
        else $error("table write outside evaluate or scan");
    a_scan_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_we) |-> count_reg != '0)
        else $error("scan took a channel with none available");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg != S_IDLE)
        else $error("sequencer idle right after accepting a word");
`endif

endmodule

@@ hw/rtl/afh_mod_unit.sv @@
// Bit-serial restoring modulo unit, one dividend bit per cycle.
// Depends on afh_pkg for widths.
module afh_mod_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [afh_pkg::MOD_DVD_W-1:0]  dividend,
    input  logic [afh_pkg::MOD_DIV_W-1:0]  divisor,
    output logic                           busy,
    output logic [afh_pkg::MOD_DIV_W-1:0]  remainder
);

    logic                          busy_reg, busy_next;
    logic [afh_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [afh_pkg::MOD_DVD_W-1:0] dvd_reg, dvd_next;
    logic [afh_pkg::MOD_DIV_W-1:0] div_reg, div_next;
    logic [afh_pkg::MOD_DIV_W-1:0] rem_reg, rem_next;
    logic [afh_pkg::MOD_DIV_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[afh_pkg::MOD_DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = afh_pkg::MOD_CNT_W'(afh_pkg::MOD_DVD_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = afh_pkg::MOD_DIV_W'(trial - {1'b0, div_reg});
            else
                rem_next = afh_pkg::MOD_DIV_W'(trial);
            dvd_next = {dvd_reg[afh_pkg::MOD_DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == afh_pkg::MOD_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modulo start while busy");
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("modulo busy with zero step count");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy_reg) && div_reg != '0) |-> rem_reg < div_reg)
        else $error("modulo remainder not below divisor");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for afh_channel_map_engine: a directed table, then random
// phases, checked word by word against listed or modelled results. Needs afh_pkg.

module testbench;
    import afh_pkg::*;

    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int NUM_WORDS    = 1950;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_FIRST   = 500;
    localparam int HOLD_SPACING = 900;
    localparam int NUM_HOLDS    = 2;

    typedef enum int {M_FAIL, M_EDGE, M_ANY} metric_mode_t;

    typedef struct packed {
        logic [1:0]      op;
        logic [CH_W-1:0] ch;
        logic [7:0]      pn, rssi, snr, prr;
    } hop_word_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            q;
        logic            none;
    } hop_res_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           data;
        hop_word_t            w;
        bit                   typed;
        hop_res_t             r;
    } plan_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation = '0;
    logic [CH_W-1:0]      channel   = '0;
    logic [7:0]           pn_value  = '0;
    logic [7:0]           rssi      = '0;
    logic [7:0]           snr       = '0;
    logic [7:0]           prr       = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CH_W-1:0]      result_channel;
    logic                 quality_ok;
    logic                 none_available;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    afh_channel_map_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .channel        (channel),
        .pn_value       (pn_value),
        .rssi           (rssi),
        .snr            (snr),
        .prr            (prr),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_channel (result_channel),
        .quality_ok     (quality_ok),
        .none_available (none_available),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // channel map mirror
    logic [1:0] tbl_status [MAX_CHANNELS];
    logic [1:0] tbl_loss   [MAX_CHANNELS];
    int         free_count = 0;
    logic [7:0] thr_rssi   = 8'd50;
    logic [7:0] thr_snr    = 8'd50;
    logic [7:0] thr_prr    = 8'd50;
    logic [7:0] num_ch     = 8'd79;
    logic [6:0] hop_step_r = 7'd7;
    logic       remap_on   = 1'b1;
    logic       replace_on = 1'b1;

    hop_res_t   hop_results_due [$];
    plan_row_t  plan [$];
    int         mismatches    = 0;
    int         words_sent    = 0;
    int         hot_ch        = 0;
    int         snd_gap_pct   = 0;
    int         rcv_stall_pct = 0;

    function automatic int map_modulus();
        int n;
        n = num_ch;
        if (n < 1)
            n = 1;
        if (n > MAP_LIMIT)
            n = MAP_LIMIT;
        return n;
    endfunction

    function automatic void set_status(int c, logic [1:0] st);
        if (c >= MAX_CHANNELS)
            return;
        if (tbl_status[c] == ST_AVAIL && free_count > 0)
            free_count--;
        if (st == ST_AVAIL)
            free_count++;
        tbl_status[c] = st;
    endfunction

    // k-th available channel, ascending; MAX_CHANNELS when there is none
    function automatic int nth_free(int k);
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (tbl_status[i] == ST_AVAIL)
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return MAX_CHANNELS;
    endfunction

    function automatic hop_res_t channel_map_step(hop_word_t w);
        hop_res_t r;
        logic     ok;
        int       c;
        int       f;
        r  = '0;
        ok = !(w.rssi < thr_rssi && w.snr < thr_snr && w.prr < thr_prr);
        case (w.op)
            OP_ASSESS:
            begin
                set_status(w.ch, ok ? ST_AVAIL : ST_UNAVAIL);
                r.ch = w.ch;
                r.q  = ok;
            end
            OP_MAP:
            begin
                if (!remap_on)
                begin
                    c = int'(w.pn) % map_modulus();
                    set_status(c, ST_USED);
                end
                else
                begin
                    c = (int'(w.pn) + int'(hop_step_r)) % map_modulus();
                    if (tbl_status[c] == ST_UNAVAIL)
                    begin
                        // unavailable hit: take the k-th free channel, or flag none
                        if (free_count == 0)
                            r.none = 1'b1;
                        else
                        begin
                            f = nth_free(c % free_count);
                            if (f < MAX_CHANNELS)
                            begin
                                c = f;
                                set_status(c, ST_USED);
                            end
                            else
                                r.none = 1'b1;
                        end
                    end
                    else
                        set_status(c, ST_USED);
                end
                r.ch = c[CH_W-1:0];
            end
            OP_MONITOR:
            begin
                r.ch = w.ch;
                r.q  = ok;
                if (int'(w.ch) < MAX_CHANNELS)
                begin
                    if (ok)
                        tbl_loss[w.ch] = '0;
                    else if (tbl_loss[w.ch] < LOSS_LIMIT)
                        tbl_loss[w.ch] = tbl_loss[w.ch] + 2'd1;
                    if (tbl_loss[w.ch] >= LOSS_LIMIT)
                    begin
                        set_status(w.ch, ST_UNAVAIL);
                        if (replace_on)
                        begin
                            f = nth_free(0);
                            if (f < MAX_CHANNELS)
                            begin
                                set_status(f, ST_USED);
                                r.ch = f[CH_W-1:0];
                            end
                            else
                                r.none = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
        case (idx)
            REG_RSSI_THR: thr_rssi   = d;
            REG_SNR_THR:  thr_snr    = d;
            REG_PRR_THR:  thr_prr    = d;
            REG_NUM_CH:   num_ch     = d;
            REG_HOP_STEP: hop_step_r = d[6:0];
            REG_REMAP:    remap_on   = d[0];
            REG_REPLACE:  replace_on = d[0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] metric(logic [7:0] thr, metric_mode_t mode);
        int v;
        case (mode)
            M_FAIL:  v = (thr == 0) ? $urandom_range(255) : $urandom_range(int'(thr) - 1);
            M_EDGE:  v = int'(thr) + int'($urandom_range(2)) - 1;
            default: v = $urandom_range(255);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic hop_word_t rand_word();
        hop_word_t    w;
        int           sel;
        int           fail_pct;
        metric_mode_t mode;
        sel = $urandom_range(99);
        if (sel < 35)
            w.op = OP_ASSESS;
        else if (sel < 65)
            w.op = OP_MAP;
        else if (sel < 95)
            w.op = OP_MONITOR;
        else
            w.op = 2'($urandom_range(3));
        // monitor keeps returning to one channel so loss runs reach the limit
        if ($urandom_range(99) < 5)
            hot_ch = $urandom_range(map_modulus() - 1);
        if (w.op == OP_MONITOR && $urandom_range(99) < 60)
            w.ch = CH_W'(hot_ch);
        else if ($urandom_range(99) < 75)
            w.ch = CH_W'($urandom_range(map_modulus() - 1));
        else
            w.ch = CH_W'($urandom_range(127));
        w.pn     = 8'($urandom_range(255));
        fail_pct = (w.op == OP_MONITOR) ? 60 : 30;
        sel      = $urandom_range(99);
        mode     = (sel < fail_pct) ? M_FAIL : (sel < fail_pct + 15) ? M_EDGE : M_ANY;
        w.rssi   = metric(thr_rssi, mode);
        w.snr    = metric(thr_snr, mode);
        w.prr    = metric(thr_prr, mode);
        return w;
    endfunction

    function automatic logic [7:0] pick_cfg(logic [CFG_IDX_W-1:0] idx);
        int sel;
        sel = $urandom_range(5);
        case (idx)
            REG_RSSI_THR, REG_SNR_THR, REG_PRR_THR:
            begin
                case (sel)
                    0:       return 8'd0;
                    1:       return 8'hFF;
                    2:       return 8'($urandom_range(255));
                    default: return 8'($urandom_range(30, 80));
                endcase
            end
            REG_NUM_CH:
            begin
                case (sel)
                    0:       return 8'd1;
                    1:       return 8'd128;
                    2:       return $urandom_range(1) ? 8'hFF : 8'd0;
                    3:       return 8'($urandom_range(2, 8));
                    default: return 8'($urandom_range(1, 128));
                endcase
            end
            REG_HOP_STEP:
            begin
                case (sel)
                    0:       return 8'd0;
                    1:       return 8'd127;
                    default: return 8'($urandom_range(255));
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic plan_row_t stim(logic [1:0] op, int ch, int pn, int rs, int sn, int pr);
        plan_row_t p;
        p.is_cfg = 1'b0;
        p.idx    = '0;
        p.data   = '0;
        p.w.op   = op;
        p.w.ch   = CH_W'(ch);
        p.w.pn   = 8'(pn);
        p.w.rssi = 8'(rs);
        p.w.snr  = 8'(sn);
        p.w.prr  = 8'(pr);
        p.typed  = 1'b0;
        p.r      = '0;
        return p;
    endfunction

    function automatic plan_row_t stim_exp(logic [1:0] op, int ch, int pn, int rs, int sn,
                                           int pr, int ech, bit eq, bit en);
        plan_row_t p;
        p        = stim(op, ch, pn, rs, sn, pr);
        p.typed  = 1'b1;
        p.r.ch   = CH_W'(ech);
        p.r.q    = eq;
        p.r.none = en;
        return p;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
        plan_row_t p;
        p        = stim(OP_UNUSED, 0, 0, 0, 0, 0);
        p.is_cfg = 1'b1;
        p.idx    = idx;
        p.data   = d;
        return p;
    endfunction

    task automatic drive_word(hop_word_t w, bit typed, hop_res_t tr);
        hop_res_t r;
        operation <= w.op;
        channel   <= w.ch;
        pn_value  <= w.pn;
        rssi      <= w.rssi;
        snr       <= w.snr;
        prr       <= w.prr;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = channel_map_step(w);
        hop_results_due.push_back(typed ? tr : r);
        words_sent++;
        if ($urandom_range(99) < snd_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat (pick_gap())
                @(posedge clk);
        end
    endtask

    // valid is still high only right after an accept, when a result is always due
    task automatic wait_results_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (hop_results_due.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it before the next word
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_cfg(idx, d);
    endtask

    task automatic check_result();
        hop_res_t e;
        if (hop_results_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: ch=%0d q=%0b none=%0b",
                         result_channel, quality_ok, none_available);
        end
        else
        begin
            e = hop_results_due.pop_front();
            if (e.ch !== result_channel || e.q !== quality_ok || e.none !== none_available)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp ch=%0d q=%0b none=%0b, got ch=%0d q=%0b none=%0b",
                             e.ch, e.q, e.none, result_channel, quality_ok, none_available);
            end
        end
    endtask

    // result side: random stalls plus a few long hold-offs to back up the input
    int stall_left = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            check_result();
        if (hold_left == 0 && holds_done < NUM_HOLDS &&
            words_sent >= HOLD_FIRST + HOLD_SPACING * holds_done)
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) < rcv_stall_pct)
        begin
            stall_left = pick_gap() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[afh_channel_map_engine] ERROR");
            $finish;
        end
    end

    initial
    begin
        bit cfg_open;
        int len;
        cfg_open = 1'b0;
        foreach (tbl_status[i])
        begin
            tbl_status[i] = ST_UNAVAIL;
            tbl_loss[i]   = '0;
        end

        // reset values: thresholds 50, 79 channels, step 7, remap and replace on
        plan.push_back(stim_exp(OP_MAP,     0,   0,   0,   0,   0,   7, 0, 1));
        plan.push_back(stim_exp(OP_ASSESS,  0,   0,   0,   0,   0,   0, 0, 0));
        plan.push_back(stim_exp(OP_ASSESS,  127, 255, 255, 255, 255, 127, 1, 0));
        plan.push_back(stim_exp(OP_ASSESS,  10,  0,   49,  255, 0,   10, 1, 0));
        plan.push_back(stim_exp(OP_ASSESS,  20,  0,   49,  49,  49,  20, 0, 0));
        plan.push_back(stim_exp(OP_ASSESS,  30,  0,   50,  0,   0,   30, 1, 0));
        plan.push_back(stim    (OP_ASSESS,  40,  0,   200, 200, 200));
        plan.push_back(stim    (OP_ASSESS,  64,  0,   90,  10,  10));
        plan.push_back(stim    (OP_MAP,     0,   33,  0,   0,   0));
        plan.push_back(stim    (OP_MAP,     0,   33,  0,   0,   0));
        plan.push_back(stim    (OP_MAP,     0,   255, 0,   0,   0));
        plan.push_back(stim_exp(OP_MONITOR, 5,   0,   0,   0,   0,   5, 0, 0));
        plan.push_back(stim_exp(OP_MONITOR, 5,   0,   0,   0,   0,   5, 0, 0));
        plan.push_back(stim    (OP_MONITOR, 5,   0,   0,   0,   0));
        plan.push_back(stim    (OP_MONITOR, 5,   0,   0,   0,   0));
        plan.push_back(stim_exp(OP_MONITOR, 5,   0,   255, 0,   0,   5, 1, 0));
        plan.push_back(stim_exp(OP_UNUSED,  127, 255, 255, 255, 255, 0, 0, 0));
        plan.push_back(cfg_row(REG_REMAP, 8'd0));
        plan.push_back(cfg_row(REG_NUM_CH, 8'd0));
        plan.push_back(stim_exp(OP_MAP,     127, 255, 0,   0,   0,   0, 0, 0));
        plan.push_back(cfg_row(REG_NUM_CH, 8'hFF));
        plan.push_back(stim_exp(OP_MAP,     0,   200, 0,   0,   0,   72, 0, 0));
        plan.push_back(cfg_row(REG_REMAP, 8'd1));
        plan.push_back(cfg_row(REG_HOP_STEP, 8'd127));
        plan.push_back(cfg_row(REG_NUM_CH, 8'd128));
        plan.push_back(stim    (OP_MAP,     0,   255, 0,   0,   0));
        plan.push_back(cfg_row(REG_REPLACE, 8'd0));
        plan.push_back(stim_exp(OP_MONITOR, 64,  0,   0,   0,   0,   64, 0, 0));
        plan.push_back(stim_exp(OP_MONITOR, 64,  0,   0,   0,   0,   64, 0, 0));
        plan.push_back(stim_exp(OP_MONITOR, 64,  0,   0,   0,   0,   64, 0, 0));
        plan.push_back(cfg_row(REG_RSSI_THR, 8'd0));
        plan.push_back(cfg_row(REG_SNR_THR, 8'd0));
        plan.push_back(cfg_row(REG_PRR_THR, 8'd0));
        plan.push_back(stim_exp(OP_ASSESS,  1,   0,   0,   0,   0,   1, 1, 0));
        plan.push_back(cfg_row(REG_RSSI_THR, 8'hFF));
        plan.push_back(cfg_row(REG_SNR_THR, 8'hFF));
        plan.push_back(cfg_row(REG_PRR_THR, 8'hFF));
        plan.push_back(stim_exp(OP_ASSESS,  2,   0,   254, 254, 254, 2, 0, 0));
        plan.push_back(stim_exp(OP_ASSESS,  3,   0,   255, 254, 254, 3, 1, 0));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_gap_pct   = 25;
        rcv_stall_pct = 20;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_results_drained();
                write_cfg(plan[i].idx, plan[i].data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                drive_word(plan[i].w, plan[i].typed, plan[i].r);
            end
        end

        while (words_sent < NUM_WORDS)
        begin
            wait_results_drained();
            for (int k = 0; k <= int'(REG_REPLACE); k++)
            begin
                if ($urandom_range(99) < 40)
                    write_cfg(CFG_IDX_W'(k), pick_cfg(CFG_IDX_W'(k)));
            end
            if ($urandom_range(99) < 5)
                write_cfg(REG_UNUSED, pick_cfg(REG_UNUSED));
            cfg_valid <= 1'b0;
            case ($urandom_range(2))
                0:       snd_gap_pct = 0;
                1:       snd_gap_pct = 15;
                default: snd_gap_pct = 50;
            endcase
            case ($urandom_range(2))
                0:       rcv_stall_pct = 0;
                1:       rcv_stall_pct = 10;
                default: rcv_stall_pct = 35;
            endcase
            len = $urandom_range(60, 200);
            repeat (len)
            begin
                if ($urandom_range(99) < 2)
                    wait_results_drained();
                drive_word(rand_word(), 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && hop_results_due.size() == 0)
            $display("[afh_channel_map_engine] OK");
        else
            $display("[afh_channel_map_engine] ERROR");
        $finish;
    end

endmodule
